/* rtl/circular_queue_with_listing_macros.svh */
// Assertion macros used by the queue controller.
// Both use the module's own clock and reset nets.
`ifndef CIRCULAR_QUEUE_WITH_LISTING_MACROS_SVH
`define CIRCULAR_QUEUE_WITH_LISTING_MACROS_SVH

// same-cycle implication
`define CQWL_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CQWL_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/cqwl_pkg.sv */
`timescale 1ns / 1ps
package cqwl_pkg;

   localparam int DEPTH    = 16;
   localparam int DATA_W   = 32;

   // fixed field widths
   localparam int PUSH_W   = 32;
   localparam int VAL_W    = 32;
   localparam int CAP_W    = 5;
   localparam int OCC_W    = 5;
   localparam int IDX_W    = 4;
   localparam int USER_W   = 4;

   localparam int PTR_W    = $clog2(DEPTH);
   localparam int CNT_W    = $clog2(DEPTH + 1);

   localparam int RSP_USED = OCC_W + 3 * VAL_W + 2 * IDX_W;
   localparam int RSP_W    = ((RSP_USED + 7) / 8) * 8;

   // slot write broadcast to the cells
   typedef struct packed {
      logic              en;
      logic [PTR_W-1:0]  addr;
      logic [DATA_W-1:0] data;
   } write_type;

   // one result travelling down the chain, picking up slot values
   typedef struct packed {
      logic             valid;
      logic             ovf;
      logic             unf;
      logic [CNT_W-1:0] occ;
      logic             full;
      logic             empty;
      logic [PTR_W-1:0] head_idx;
      logic [PTR_W-1:0] tail_idx;
      logic [PTR_W-1:0] list_idx;
      logic             last;
      logic [VAL_W-1:0] head_val;
      logic [VAL_W-1:0] tail_val;
      logic [VAL_W-1:0] list_val;
   } token_type;

endpackage

/* rtl/circular_queue_with_listing.sv */
`timescale 1ns / 1ps
// Circular queue of 32-bit values, capacity set by csr_wr_data (1 to DEPTH,
// 0 acts as 1, above DEPTH acts as DEPTH; write only while idle). Each
// req transaction either enqueues req_tdata (req_tuser = 0) or dequeues the
// front (req_tuser = 1); a push to a full queue or a pop from an empty one is
// refused and flagged. Every operation answers with a run of rsp transactions,
// one per held entry from front to rear (a single one when empty), each with
// the same status and rsp_tlast on the final one. Timing: one operation at a
// time; the results of an operation are issued into the slot chain one per
// cycle while the chain advances, and req_tready returns the cycle after the
// last one is taken. The whole chain holds while a result waits at the output.
// Each result walks through DEPTH cells, one per cycle when not held,
// collecting the slot values it needs.
// No clearing pass after reset.
module circular_queue_with_listing import cqwl_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [PUSH_W-1:0] req_tdata,   // push_value
   input  logic              req_tuser,   // kind
   // response channel
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_W-1:0]  rsp_tdata,   // occupancy, head_value, head_index,
                                          // tail_value, tail_index, listed_value, pad
   output logic [USER_W-1:0] rsp_tuser,   // overflow, underflow, is_full, is_empty
   output logic              rsp_tlast,   // last
   // capacity register
   input  logic              csr_wr_en,
   input  logic [CAP_W-1:0]  csr_wr_data
);

   write_type wr;
   token_type chain_tok [DEPTH+1];
   token_type out_tok;
   logic      chain_adv;
   logic      run_done;

   // whole chain holds while the final cell's result waits to be taken
   assign out_tok   = chain_tok[DEPTH];
   assign chain_adv = !(out_tok.valid && !rsp_tready);
   assign run_done  = out_tok.valid && rsp_tready && out_tok.last;

   cqwl_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .chain_adv   (chain_adv),
      .run_done    (run_done),
      .wr          (wr),
      .tok         (chain_tok[0])
   );

   // one cell per slot; a result enters at cell 0 and leaves from the last
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      cqwl_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .chain_adv  (chain_adv),
         .cell_index (PTR_W'(i)),
         .wr         (wr),
         .tok_prev   (chain_tok[i]),
         .tok_next   (chain_tok[i+1])
      );
   end

   // final cell's register is the output register
   assign rsp_tvalid = out_tok.valid;
   assign rsp_tlast  = out_tok.last;
   assign rsp_tuser  = {out_tok.empty, out_tok.full, out_tok.unf, out_tok.ovf};
   assign rsp_tdata  = {{(RSP_W - RSP_USED){1'b0}},
                        out_tok.list_val,
                        IDX_W'(out_tok.tail_idx),
                        out_tok.tail_val,
                        IDX_W'(out_tok.head_idx),
                        out_tok.head_val,
                        OCC_W'(out_tok.occ)};

endmodule

/* rtl/cqwl_cell.sv */
`timescale 1ns / 1ps
module cqwl_cell import cqwl_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             chain_adv,
   input  logic [PTR_W-1:0] cell_index,
   input  write_type        wr,
   input  token_type        tok_prev,
   output token_type        tok_next
);

   logic [DATA_W-1:0] slot_ff, slot_in;
   token_type         tok_ff, tok_in;

   always_comb begin
      slot_in = slot_ff;
      if (wr.en && (wr.addr == cell_index)) begin
         slot_in = wr.data;
      end
   end

   // substitute this slot wherever the passing result refers to it
   always_comb begin
      tok_in = tok_prev;
      if (tok_prev.valid && !tok_prev.empty) begin
         if (tok_prev.head_idx == cell_index) begin
            tok_in.head_val = VAL_W'(slot_ff);
         end
         if (tok_prev.tail_idx == cell_index) begin
            tok_in.tail_val = VAL_W'(slot_ff);
         end
         if (tok_prev.list_idx == cell_index) begin
            tok_in.list_val = VAL_W'(slot_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else if (chain_adv) begin
         tok_ff <= tok_in;
      end
   end

   assign tok_next = tok_ff;

endmodule

/* rtl/cqwl_ctrl.sv */
`timescale 1ns / 1ps
`include "circular_queue_with_listing_macros.svh"
module cqwl_ctrl import cqwl_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic              req_tuser,
   input  logic [PUSH_W-1:0] req_tdata,
   input  logic              csr_wr_en,
   input  logic [CAP_W-1:0]  csr_wr_data,
   input  logic              chain_adv,
   input  logic              run_done,
   output write_type         wr,
   output token_type         tok
);

   localparam logic KIND_PUSH = 1'b0;

   typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_DRAIN} state_type;

   state_type        state_ff, state_in;
   logic [CAP_W-1:0] cap_ff, cap_in;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             ovf_ff, ovf_in;
   logic             unf_ff, unf_in;
   logic [PTR_W-1:0] list_ff, list_in;
   logic [CNT_W-1:0] issued_ff, issued_in;

   logic [CNT_W-1:0] eff_cap;
   logic [CNT_W-1:0] run_len;
   logic [PTR_W-1:0] rear;
   logic             is_empty;
   logic             accept;

   function automatic logic [PTR_W-1:0] adv_ptr(input logic [PTR_W-1:0] p,
                                                input logic [CNT_W-1:0] c);
      logic [CNT_W-1:0] n;
      n = CNT_W'(p) + CNT_W'(1);
      return (n >= c) ? '0 : PTR_W'(n);
   endfunction

   // zero acts as one, anything above the depth as the depth
   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = CNT_W'(1);
      end else if ({1'b0, cap_ff} > (CAP_W + 1)'(DEPTH)) begin
         eff_cap = CNT_W'(DEPTH);
      end else begin
         eff_cap = CNT_W'(cap_ff);
      end
   end

   assign accept     = req_tvalid && (state_ff == ST_IDLE);
   assign req_tready = (state_ff == ST_IDLE);
   assign is_empty   = (fill_ff == '0);
   assign rear       = (tail_ff == '0) ? PTR_W'(eff_cap - CNT_W'(1)) : tail_ff - PTR_W'(1);
   assign run_len    = is_empty ? CNT_W'(1) : fill_ff;

   always_comb begin
      tok.valid    = (state_ff == ST_ISSUE);
      tok.ovf      = ovf_ff;
      tok.unf      = unf_ff;
      tok.occ      = fill_ff;
      tok.full     = (fill_ff >= eff_cap);
      tok.empty    = is_empty;
      tok.head_idx = is_empty ? '0 : head_ff;
      tok.tail_idx = is_empty ? '0 : rear;
      tok.list_idx = list_ff;
      tok.last     = ((issued_ff + CNT_W'(1)) == run_len);
      tok.head_val = '0;
      tok.tail_val = '0;
      tok.list_val = '0;
   end

   always_comb begin
      state_in  = state_ff;
      cap_in    = cap_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      fill_in   = fill_ff;
      ovf_in    = ovf_ff;
      unf_in    = unf_ff;
      list_in   = list_ff;
      issued_in = issued_ff;
      wr.en     = 1'b0;
      wr.addr   = tail_ff;
      wr.data   = DATA_W'(req_tdata);

      if (csr_wr_en) begin
         cap_in = csr_wr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ovf_in = 1'b0;
               unf_in = 1'b0;
               if (req_tuser == KIND_PUSH) begin
                  if (fill_ff >= eff_cap) begin
                     ovf_in = 1'b1;
                  end else begin
                     wr.en   = 1'b1;
                     tail_in = adv_ptr(tail_ff, eff_cap);
                     fill_in = fill_ff + CNT_W'(1);
                  end
               end else begin
                  if (fill_ff == '0) begin
                     unf_in = 1'b1;
                  end else begin
                     head_in = adv_ptr(head_ff, eff_cap);
                     fill_in = fill_ff - CNT_W'(1);
                  end
               end
               list_in   = head_in;
               issued_in = '0;
               state_in  = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            if (chain_adv) begin
               issued_in = issued_ff + CNT_W'(1);
               list_in   = adv_ptr(list_ff, eff_cap);
               if (tok.last) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (run_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cap_ff   <= CAP_W'(DEPTH);
         head_ff  <= '0;
         tail_ff  <= '0;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         cap_ff   <= cap_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         fill_ff  <= fill_in;
      end
      ovf_ff    <= ovf_in;
      unf_ff    <= unf_in;
      list_ff   <= list_in;
      issued_ff <= issued_in;
   end

   `CQWL_ASSERT_NEXT(a_accept_issue, accept, state_ff == ST_ISSUE, "accept did not start issue")
   `CQWL_ASSERT_NOW(a_fill_bound, 1'b1, fill_ff <= CNT_W'(DEPTH), "fill count beyond depth")
   `CQWL_ASSERT_NEXT(a_last_drain, tok.valid && tok.last && chain_adv, state_ff == ST_DRAIN, "no drain after last")
   `CQWL_ASSERT_NOW(a_flags_excl, tok.valid, !(tok.ovf && tok.unf), "overflow and underflow together")

endmodule
